[hdl/assert_macros.svh]
// Assertion macros used by the port checker of the point projection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define PPBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the following cycle.
`define PPBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/ppbs_pkg.sv]
// Package with widths, types and register codes of the point projection block.
`default_nettype none
package ppbs_pkg;

    localparam int DEF_COORD_FRAC_BITS = 12;

    localparam int COEF_W  = 16;
    localparam int COORD_W = 24;
    localparam int PROD_W  = 40;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int CLIP_W  = PROD_W + 3;
    localparam int NSUM_W  = CLIP_W + 1;
    localparam int DEN_W   = NSUM_W;
    localparam int VP_W    = 16;
    localparam int NUM_W   = NSUM_W + VP_W + 1;
    localparam int Q_W     = 22;
    localparam int REM_W   = DEN_W + Q_W;
    localparam int DIV_STAGES = Q_W + 1;
    localparam int PIX_W   = 21;
    localparam int SUM_W   = PIX_W + 3;
    localparam int BOX_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X    = 3'd0,
        REG_ROW_Y    = 3'd1,
        REG_ROW_W    = 3'd2,
        REG_VIEWPORT = 3'd3,
        REG_BOX_LO   = 3'd4,
        REG_BOX_HI   = 3'd5,
        REG_MODE     = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic shown;
        logic wz;
    } ctl_t;

    typedef struct packed {
        logic [NUM_W-1:0] mag;
        logic             neg;
    } num_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             neg;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           neg;
        logic           ovf;
    } quo_t;

endpackage
`default_nettype wire

[hdl/ppbs_clip.sv]
// Matrix stages: products of the three rows with the point, then two adder levels.
`default_nettype none
module ppbs_clip #(
    parameter int COORD_FRAC_BITS = ppbs_pkg::DEF_COORD_FRAC_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic signed [ppbs_pkg::COORD_W-1:0] in_x,
    input  wire logic signed [ppbs_pkg::COORD_W-1:0] in_y,
    input  wire logic signed [ppbs_pkg::COORD_W-1:0] in_z,
    input  wire logic                               in_shown,
    input  wire logic [63:0]                        row_x,
    input  wire logic [63:0]                        row_y,
    input  wire logic [63:0]                        row_w,
    output logic                                    out_valid,
    output ppbs_pkg::ctl_t                          out_ctl,
    output logic signed [ppbs_pkg::CLIP_W-1:0]      cx,
    output logic signed [ppbs_pkg::CLIP_W-1:0]      cy,
    output logic signed [ppbs_pkg::CLIP_W-1:0]      cw
);
    localparam int CE = ppbs_pkg::PROD_W - ppbs_pkg::COEF_W;
    localparam int PE = ppbs_pkg::PROD_W - ppbs_pkg::COORD_W;

    logic [63:0] rows [3];
    logic signed [ppbs_pkg::PROD_W-1:0] prod_next [3][4];
    logic signed [ppbs_pkg::PROD_W-1:0] prod_reg  [3][4];
    logic signed [ppbs_pkg::PAIR_W-1:0] pair_next [3][2];
    logic signed [ppbs_pkg::PAIR_W-1:0] pair_reg  [3][2];
    logic signed [ppbs_pkg::CLIP_W-1:0] clip_next [3];
    logic signed [ppbs_pkg::CLIP_W-1:0] clip_reg  [3];
    logic [2:0] valid_reg;
    logic [2:0] shown_reg;
    logic signed [ppbs_pkg::PROD_W-1:0] px;
    logic signed [ppbs_pkg::PROD_W-1:0] py;
    logic signed [ppbs_pkg::PROD_W-1:0] pz;

    assign rows[0] = row_x;
    assign rows[1] = row_y;
    assign rows[2] = row_w;
    assign px = $signed({{PE{in_x[ppbs_pkg::COORD_W-1]}}, in_x});
    assign py = $signed({{PE{in_y[ppbs_pkg::COORD_W-1]}}, in_y});
    assign pz = $signed({{PE{in_z[ppbs_pkg::COORD_W-1]}}, in_z});

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            prod_next[r][0] = $signed({{CE{rows[r][15]}}, rows[r][15:0]}) * px;
            prod_next[r][1] = $signed({{CE{rows[r][31]}}, rows[r][31:16]}) * py;
            prod_next[r][2] = $signed({{CE{rows[r][47]}}, rows[r][47:32]}) * pz;
            prod_next[r][3] = $signed({{CE{rows[r][63]}}, rows[r][63:48]}) <<< COORD_FRAC_BITS;
            pair_next[r][0] = $signed({prod_reg[r][0][ppbs_pkg::PROD_W-1], prod_reg[r][0]})
                            + $signed({prod_reg[r][1][ppbs_pkg::PROD_W-1], prod_reg[r][1]});
            pair_next[r][1] = $signed({prod_reg[r][2][ppbs_pkg::PROD_W-1], prod_reg[r][2]})
                            + $signed({prod_reg[r][3][ppbs_pkg::PROD_W-1], prod_reg[r][3]});
            clip_next[r] = $signed({{2{pair_reg[r][0][ppbs_pkg::PAIR_W-1]}}, pair_reg[r][0]})
                         + $signed({{2{pair_reg[r][1][ppbs_pkg::PAIR_W-1]}}, pair_reg[r][1]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shown_reg <= {shown_reg[1:0], in_shown};
            prod_reg  <= prod_next;
            pair_reg  <= pair_next;
            clip_reg  <= clip_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_ctl   = '{shown: shown_reg[2], wz: 1'b0};
    assign cx = clip_reg[0];
    assign cy = clip_reg[1];
    assign cw = clip_reg[2];
endmodule
`default_nettype wire

[hdl/ppbs_ratio.sv]
// Viewport numerators, denominator, zero-w detection and sign/magnitude split.
`default_nettype none
module ppbs_ratio (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire ppbs_pkg::ctl_t                     in_ctl,
    input  wire logic signed [ppbs_pkg::CLIP_W-1:0] cx,
    input  wire logic signed [ppbs_pkg::CLIP_W-1:0] cy,
    input  wire logic signed [ppbs_pkg::CLIP_W-1:0] cw,
    input  wire logic [ppbs_pkg::VP_W-1:0]          vp_width,
    input  wire logic [ppbs_pkg::VP_W-1:0]          vp_height,
    output logic                                    out_valid,
    output ppbs_pkg::ctl_t                          out_ctl,
    output ppbs_pkg::num_t                          num_x,
    output ppbs_pkg::num_t                          num_y,
    output logic [ppbs_pkg::DEN_W-1:0]              den_mag
);
    localparam int NE = ppbs_pkg::NUM_W - ppbs_pkg::NSUM_W;
    localparam int WE = ppbs_pkg::NUM_W - ppbs_pkg::VP_W;
    localparam int CW = ppbs_pkg::CLIP_W;
    localparam int NW = ppbs_pkg::NUM_W;
    localparam int DW = ppbs_pkg::DEN_W;

    logic [2:0] valid_reg;
    ppbs_pkg::ctl_t ctl1_reg, ctl2_reg, ctl3_reg;
    logic signed [ppbs_pkg::NSUM_W-1:0] nx_reg, ny_reg;
    logic signed [DW-1:0] den1_reg, den2_reg;
    logic signed [NW-1:0] mx_reg, my_reg;
    ppbs_pkg::num_t numx_reg, numy_reg;
    logic [DW-1:0] dmag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl1_reg <= '{shown: in_ctl.shown, wz: (cw == '0)};
            nx_reg   <= $signed({cx[CW-1], cx}) + $signed({cw[CW-1], cw});
            ny_reg   <= $signed({cw[CW-1], cw}) - $signed({cy[CW-1], cy});
            den1_reg <= $signed({cw, 1'b0});
            ctl2_reg <= ctl1_reg;
            den2_reg <= den1_reg;
            mx_reg   <= $signed({{WE{1'b0}}, vp_width}) * $signed({{NE{nx_reg[DW-1]}}, nx_reg});
            my_reg   <= $signed({{WE{1'b0}}, vp_height}) * $signed({{NE{ny_reg[DW-1]}}, ny_reg});
            ctl3_reg <= ctl2_reg;
            numx_reg.mag <= mx_reg[NW-1] ? NW'(-mx_reg) : NW'(mx_reg);
            numx_reg.neg <= mx_reg[NW-1] ^ den2_reg[DW-1];
            numy_reg.mag <= my_reg[NW-1] ? NW'(-my_reg) : NW'(my_reg);
            numy_reg.neg <= my_reg[NW-1] ^ den2_reg[DW-1];
            dmag_reg <= den2_reg[DW-1] ? DW'(-den2_reg) : DW'(den2_reg);
        end
    end

    assign out_valid = valid_reg[2];
    assign out_ctl   = ctl3_reg;
    assign num_x     = numx_reg;
    assign num_y     = numy_reg;
    assign den_mag   = dmag_reg;
endmodule
`default_nettype wire

[hdl/ppbs_div.sv]
// Pipelined restoring divider, one quotient bit per stage, for both screen axes.
`default_nettype none
module ppbs_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire ppbs_pkg::ctl_t                in_ctl,
    input  wire ppbs_pkg::num_t                num_x,
    input  wire ppbs_pkg::num_t                num_y,
    input  wire logic [ppbs_pkg::DEN_W-1:0]    den_mag,
    output logic                               out_valid,
    output ppbs_pkg::ctl_t                     out_ctl,
    output ppbs_pkg::quo_t                     quo_x,
    output ppbs_pkg::quo_t                     quo_y
);
    localparam int NS = ppbs_pkg::DIV_STAGES;

    logic [NS-1:0] valid_reg;
    ppbs_pkg::lane_t lx_reg [NS];
    ppbs_pkg::lane_t ly_reg [NS];
    logic [ppbs_pkg::DEN_W-1:0] den_reg [NS];
    ppbs_pkg::ctl_t ctl_reg [NS];

    function automatic ppbs_pkg::lane_t init_lane(ppbs_pkg::num_t n,
                                                  logic [ppbs_pkg::DEN_W-1:0] d);
        ppbs_pkg::lane_t l;
        l.rem = ppbs_pkg::REM_W'(n.mag);
        l.q   = '0;
        l.neg = n.neg;
        l.ovf = (l.rem >= {d, {ppbs_pkg::Q_W{1'b0}}});
        return l;
    endfunction

    function automatic ppbs_pkg::lane_t step_lane(ppbs_pkg::lane_t l,
                                                  logic [ppbs_pkg::DEN_W-1:0] d, int b);
        ppbs_pkg::lane_t o;
        logic [ppbs_pkg::REM_W-1:0] sub;
        o   = l;
        sub = ppbs_pkg::REM_W'(d) << b;
        if (l.rem >= sub)
        begin
            o.rem  = l.rem - sub;
            o.q[b] = 1'b1;
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lx_reg[0]  <= init_lane(num_x, den_mag);
            ly_reg[0]  <= init_lane(num_y, den_mag);
            den_reg[0] <= den_mag;
            ctl_reg[0] <= in_ctl;
        end
    end

    for (genvar j = 1; j < NS; j++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lx_reg[j]  <= step_lane(lx_reg[j-1], den_reg[j-1], ppbs_pkg::Q_W - j);
                ly_reg[j]  <= step_lane(ly_reg[j-1], den_reg[j-1], ppbs_pkg::Q_W - j);
                den_reg[j] <= den_reg[j-1];
                ctl_reg[j] <= ctl_reg[j-1];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_ctl   = ctl_reg[NS-1];
    assign quo_x     = '{q: lx_reg[NS-1].q, neg: lx_reg[NS-1].neg, ovf: lx_reg[NS-1].ovf};
    assign quo_y     = '{q: ly_reg[NS-1].q, neg: ly_reg[NS-1].neg, ovf: ly_reg[NS-1].ovf};
endmodule
`default_nettype wire

[hdl/ppbs_screen.sv]
// Screen stages: signed quotient plus origin with saturation, then the box test and mode select.
`default_nettype none
module ppbs_screen (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire ppbs_pkg::ctl_t               in_ctl,
    input  wire ppbs_pkg::quo_t               quo_x,
    input  wire ppbs_pkg::quo_t               quo_y,
    input  wire logic [ppbs_pkg::VP_W-1:0]    origin_x,
    input  wire logic [ppbs_pkg::VP_W-1:0]    origin_y,
    input  wire logic [31:0]                  box_lo,
    input  wire logic [31:0]                  box_hi,
    input  wire logic                         mode,
    output logic                              out_valid,
    output logic                              shown_out,
    output logic                              inside_box,
    output logic signed [ppbs_pkg::PIX_W-1:0] pixel_x,
    output logic signed [ppbs_pkg::PIX_W-1:0] pixel_y,
    output logic                              w_zero
);
    localparam int PW = ppbs_pkg::PIX_W;
    localparam int SW = ppbs_pkg::SUM_W;
    localparam int BE = ppbs_pkg::PIX_W - ppbs_pkg::BOX_W;

    logic [1:0] valid_reg;
    ppbs_pkg::ctl_t ctl_reg;
    logic signed [PW-1:0] sx_reg, sy_reg;
    logic shown_reg, inside_reg, wz_reg;
    logic signed [PW-1:0] px_reg, py_reg;
    logic signed [PW-1:0] lo_x, lo_y, hi_x, hi_y;
    logic inside_next;

    function automatic logic signed [PW-1:0] to_pix(ppbs_pkg::quo_t q,
                                                    logic [ppbs_pkg::VP_W-1:0] org);
        logic signed [SW-1:0] qs;
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        qs  = $signed({{(SW-ppbs_pkg::Q_W){1'b0}}, q.q});
        qs  = q.neg ? -qs : qs;
        sum = qs + $signed({{(SW-ppbs_pkg::VP_W){1'b0}}, org});
        hi  = ppbs_pkg::PIX_MAX;
        lo  = ppbs_pkg::PIX_MIN;
        if (q.ovf)
        begin
            return q.neg ? ppbs_pkg::PIX_MIN : ppbs_pkg::PIX_MAX;
        end
        if (sum > hi)
        begin
            return ppbs_pkg::PIX_MAX;
        end
        if (sum < lo)
        begin
            return ppbs_pkg::PIX_MIN;
        end
        return PW'(sum);
    endfunction

    assign lo_x = $signed({{BE{box_lo[15]}}, box_lo[15:0]});
    assign lo_y = $signed({{BE{box_lo[31]}}, box_lo[31:16]});
    assign hi_x = $signed({{BE{box_hi[15]}}, box_hi[15:0]});
    assign hi_y = $signed({{BE{box_hi[31]}}, box_hi[31:16]});
    assign inside_next = (sx_reg >= lo_x) && (sx_reg <= hi_x)
                      && (sy_reg >= lo_y) && (sy_reg <= hi_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= in_ctl;
            sx_reg  <= to_pix(quo_x, origin_x);
            sy_reg  <= to_pix(quo_y, origin_y);
            if (!ctl_reg.shown || ctl_reg.wz)
            begin
                shown_reg  <= ctl_reg.shown;
                inside_reg <= 1'b0;
                px_reg     <= '0;
                py_reg     <= '0;
                wz_reg     <= ctl_reg.shown;
            end
            else
            begin
                shown_reg  <= mode ? !inside_next : inside_next;
                inside_reg <= inside_next;
                px_reg     <= sx_reg;
                py_reg     <= sy_reg;
                wz_reg     <= 1'b0;
            end
        end
    end

    assign out_valid  = valid_reg[1];
    assign shown_out  = shown_reg;
    assign inside_box = inside_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign w_zero     = wz_reg;
endmodule
`default_nettype wire

[hdl/point_project_box_select.sv]
// Top level of the point projection and box selection pipeline.
// An input transaction passes through 3 matrix, 3 ratio, 23 divider and 2 screen stages
// before it leaves as an output transaction.
// One point is accepted every cycle in which the whole pipeline advances, that is while the output is free.
// Reset clears all valid bits and all configuration registers to zero.
`default_nettype none
module point_project_box_select #(
    parameter int COORD_FRAC_BITS = ppbs_pkg::DEF_COORD_FRAC_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // point_x, point_y, point_z
    input  wire logic [0:0]  s_tuser,   // shown_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // pixel_x, pixel_y, zero fill
    output logic [2:0]       m_tuser,   // shown_out, inside_box, w_zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [ppbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ppbs_pkg::CFG_DATA_W-1:0] cfg_data
);
    logic [63:0] row_x_reg, row_y_reg, row_w_reg, viewport_reg;
    logic [31:0] box_lo_reg, box_hi_reg;
    logic        mode_reg;
    logic        adv;

    logic clip_valid, ratio_valid, div_valid, out_valid;
    ppbs_pkg::ctl_t clip_ctl, ratio_ctl, div_ctl;
    logic signed [ppbs_pkg::CLIP_W-1:0] cx, cy, cw;
    ppbs_pkg::num_t num_x, num_y;
    logic [ppbs_pkg::DEN_W-1:0] den_mag;
    ppbs_pkg::quo_t quo_x, quo_y;
    logic shown_out, inside_box, w_zero;
    logic signed [ppbs_pkg::PIX_W-1:0] pixel_x, pixel_y;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid || m_tready;
    assign s_tready  = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg    <= '0;
            row_y_reg    <= '0;
            row_w_reg    <= '0;
            viewport_reg <= '0;
            box_lo_reg   <= '0;
            box_hi_reg   <= '0;
            mode_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (ppbs_pkg::reg_index_t'(cfg_index))
                ppbs_pkg::REG_ROW_X:    row_x_reg    <= cfg_data;
                ppbs_pkg::REG_ROW_Y:    row_y_reg    <= cfg_data;
                ppbs_pkg::REG_ROW_W:    row_w_reg    <= cfg_data;
                ppbs_pkg::REG_VIEWPORT: viewport_reg <= cfg_data;
                ppbs_pkg::REG_BOX_LO:   box_lo_reg   <= cfg_data[31:0];
                ppbs_pkg::REG_BOX_HI:   box_hi_reg   <= cfg_data[31:0];
                ppbs_pkg::REG_MODE:     mode_reg     <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    ppbs_clip #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_x      ($signed(s_tdata[23:0])),
        .in_y      ($signed(s_tdata[47:24])),
        .in_z      ($signed(s_tdata[71:48])),
        .in_shown  (s_tuser[0]),
        .row_x     (row_x_reg),
        .row_y     (row_y_reg),
        .row_w     (row_w_reg),
        .out_valid (clip_valid),
        .out_ctl   (clip_ctl),
        .cx        (cx),
        .cy        (cy),
        .cw        (cw)
    );

    ppbs_ratio u_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (clip_valid),
        .in_ctl    (clip_ctl),
        .cx        (cx),
        .cy        (cy),
        .cw        (cw),
        .vp_width  (viewport_reg[47:32]),
        .vp_height (viewport_reg[63:48]),
        .out_valid (ratio_valid),
        .out_ctl   (ratio_ctl),
        .num_x     (num_x),
        .num_y     (num_y),
        .den_mag   (den_mag)
    );

    ppbs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (ratio_valid),
        .in_ctl    (ratio_ctl),
        .num_x     (num_x),
        .num_y     (num_y),
        .den_mag   (den_mag),
        .out_valid (div_valid),
        .out_ctl   (div_ctl),
        .quo_x     (quo_x),
        .quo_y     (quo_y)
    );

    ppbs_screen u_screen (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (div_valid),
        .in_ctl     (div_ctl),
        .quo_x      (quo_x),
        .quo_y      (quo_y),
        .origin_x   (viewport_reg[15:0]),
        .origin_y   (viewport_reg[31:16]),
        .box_lo     (box_lo_reg),
        .box_hi     (box_hi_reg),
        .mode       (mode_reg),
        .out_valid  (out_valid),
        .shown_out  (shown_out),
        .inside_box (inside_box),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .w_zero     (w_zero)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {6'b0, pixel_y, pixel_x};
    assign m_tuser  = {w_zero, inside_box, shown_out};
endmodule
`default_nettype wire

[hdl/ppbs_checker.sv]
// Port checker for the point projection block and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module ppbs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [2:0]  m_tuser
);
    `PPBS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `PPBS_ASSERT_IMP(a_wzero_result, clk, rst_n, m_tvalid && m_tuser[2], m_tuser[0] && !m_tuser[1] && (m_tdata == 48'd0))
    `PPBS_ASSERT_IMP(a_inside_not_wzero, clk, rst_n, m_tvalid && m_tuser[1], !m_tuser[2])
    `PPBS_ASSERT_IMP(a_ready_follows_out, clk, rst_n, 1'b1, s_tready == (!m_tvalid || m_tready))
endmodule

bind point_project_box_select ppbs_checker u_ppbs_checker (.*);
`default_nettype wire
